// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/hof_pkg.sv =====
// shared types, constants and helpers for the hampel outlier filter
// no dependencies
package hof_pkg;

  localparam int HALF_WINDOW = 3;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int PTR_W       = $clog2(WIN_LEN);
  localparam int CNT_W       = $clog2(2 * HALF_WINDOW + 1);
  localparam int RANK_CNT_W  = $clog2(WIN_LEN + 1);

  localparam int SAMPLE_W = 16;
  localparam int DEV_W    = 16;
  localparam int RANK_W   = SAMPLE_W + 1;
  localparam int SCALE_W  = 12;
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = SCALE_W + DEV_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(1139);
  localparam logic [PTR_W-1:0]   LAST_SLOT    = PTR_W'(2 * HALF_WINDOW);
  localparam logic [PTR_W-1:0]   CENTER_RESET = PTR_W'(HALF_WINDOW - 1);
  localparam logic [CNT_W-1:0]   WARM_DONE    = CNT_W'(2 * HALF_WINDOW);
  localparam logic [PTR_W-1:0]   IDX_LAST     = PTR_W'(WIN_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED,
    ST_DEV,
    ST_MAD,
    ST_MULT,
    ST_FINISH
  } hof_state_t;

  typedef struct packed {
    logic             accept;
    logic             rank_step;
    logic             mad_phase;
    logic             dev_load;
    logic             mult;
    logic             finish;
    logic [PTR_W-1:0] idx;
  } hof_cmd_t;

  typedef struct packed {
    logic warm;
    logic out_busy;
  } hof_status_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == IDX_LAST) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

// ===== src/hof_ctrl.sv =====
// sequencer for the hampel outlier filter: request handshake and phase order
// depends on hof_pkg
module hof_ctrl
  import hof_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hof_status_t sts,
  output hof_cmd_t    cmd
);

  hof_state_t       state, state_next;
  logic [PTR_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      ST_IDLE: begin
        // warmup results leave at once, so they need a free output slot
        in_ready = sts.warm ? !sts.out_busy : 1'b1;
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (!sts.warm) begin
            state_next = ST_MED;
            idx_next   = '0;
          end
        end
      end
      ST_MED: begin
        cmd.rank_step = 1'b1;
        idx_next      = ring_next(idx);
        if (idx == IDX_LAST) begin
          state_next = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd.dev_load = 1'b1;
        idx_next     = '0;
        state_next   = ST_MAD;
      end
      ST_MAD: begin
        cmd.rank_step = 1'b1;
        cmd.mad_phase = 1'b1;
        idx_next      = ring_next(idx);
        if (idx == IDX_LAST) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/hof_datapath.sv =====
// window ring, rank-count unit, deviation lanes, threshold multiply, result register
// depends on hof_pkg
module hof_datapath
  import hof_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  hof_cmd_t                   cmd,
  output hof_status_t                sts,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_we,
  input  logic [SCALE_W-1:0]         cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       replaced,
  output logic                       warming_up
);

  function automatic logic [DEV_W-1:0] abs_dev(input logic signed [SAMPLE_W-1:0] a,
                                               input logic signed [SAMPLE_W-1:0] b);
    logic signed [RANK_W-1:0] d;
    d = RANK_W'(a) - RANK_W'(b);
    if (d < 0) begin
      d = -d;
    end
    return d[DEV_W-1:0];
  endfunction

  logic signed [SAMPLE_W-1:0] win [WIN_LEN];
  logic signed [RANK_W-1:0]   rank [WIN_LEN];
  logic [PTR_W-1:0]           wp, cp, wp_n;
  logic [CNT_W-1:0]           warm_cnt;
  logic [SCALE_W-1:0]         scale;
  logic signed [SAMPLE_W-1:0] med;
  logic [DEV_W-1:0]           mad, devc;
  logic [PROD_W-1:0]          prod;

  logic signed [RANK_W-1:0]   cand;
  logic [RANK_CNT_W-1:0]      less_cnt, leq_cnt;
  logic                       hit, warm, repl;
  logic signed [SAMPLE_W-1:0] center_val;

  assign warm       = warm_cnt < WARM_DONE;
  assign wp_n       = ring_next(wp);
  assign center_val = win[cp];
  assign repl       = (PROD_W'(devc) << FRAC_W) > prod;

  assign sts.warm     = warm;
  assign sts.out_busy = out_valid && !out_ready;

  // rank of the candidate among all lanes
  always_comb begin
    cand     = rank[cmd.idx];
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < WIN_LEN; j++) begin
      less_cnt = less_cnt + RANK_CNT_W'(rank[j] < cand);
      leq_cnt  = leq_cnt + RANK_CNT_W'(rank[j] <= cand);
    end
    hit = (less_cnt <= RANK_CNT_W'(HALF_WINDOW)) && (leq_cnt > RANK_CNT_W'(HALF_WINDOW));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= LAST_SLOT;
      cp        <= CENTER_RESET;
      warm_cnt  <= '0;
      scale     <= SCALE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      if (cmd.accept) begin
        wp <= wp_n;
        if (warm) begin
          warm_cnt <= warm_cnt + CNT_W'(1);
        end else begin
          cp <= ring_next(cp);
        end
      end
      if ((cmd.accept && warm) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win[wp_n] <= sample;
      if (warm) begin
        filtered   <= sample;
        replaced   <= 1'b0;
        warming_up <= 1'b1;
      end else begin
        for (int j = 0; j < WIN_LEN; j++) begin
          rank[j] <= (PTR_W'(j) == wp_n) ? RANK_W'(sample) : RANK_W'(win[j]);
        end
      end
    end
    if (cmd.rank_step && hit) begin
      if (cmd.mad_phase) begin
        mad <= cand[DEV_W-1:0];
      end else begin
        med <= cand[SAMPLE_W-1:0];
      end
    end
    if (cmd.dev_load) begin
      for (int j = 0; j < WIN_LEN; j++) begin
        rank[j] <= RANK_W'({1'b0, abs_dev(win[j], med)});
      end
      devc <= abs_dev(center_val, med);
    end
    if (cmd.mult) begin
      prod <= PROD_W'(scale) * PROD_W'(mad);
    end
    if (cmd.finish) begin
      if (repl) begin
        win[cp] <= med;
      end
      filtered   <= repl ? med : center_val;
      replaced   <= repl;
      warming_up <= 1'b0;
    end
  end

endmodule

// ===== src/hampel_outlier_filter_top.sv =====
// top level of the hampel outlier filter: sequencer plus datapath
// depends on hof_pkg, hof_ctrl, hof_datapath and assert_macros.svh
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   input    | in_valid / in_ready   | sample (s16)
//   output   | out_valid / out_ready | filtered (s16), replaced, warming_up
//   config   | cfg_we                | cfg_wdata (outlier_scale, u12 q4.8)
//
// the first 2*HALF_WINDOW requests are warmup: each goes straight to the
// output register, taken only while that register is free
// after warmup a request runs through these steps in order: one accept,
// a rank-count sweep for the median, one deviation load, a rank-count sweep
// for the mad, one multiply, one finish; each sweep steps through the window,
// one window entry per cycle
// the finish step waits while the previous result is still stalled on the
// output; a new request is accepted while a finished result waits
// rst is synchronous; the window ring is not cleared, warmup and the first filtering request fill it
`include "assert_macros.svh"

module hampel_outlier_filter_top
  import hof_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       replaced,
  output logic                       warming_up,
  input  logic                       cfg_we,
  input  logic [SCALE_W-1:0]         cfg_wdata
);

  // commands from the sequencer and status back from the datapath
  hof_cmd_t    cmd;
  hof_status_t sts;

  hof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hof_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample     (sample),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .replaced   (replaced),
    .warming_up (warming_up)
  );

  // a result is only written into a free output slot
  `ASSERT_IMPLY(a_finish_free, clk, rst, cmd.finish, !(out_valid && !out_ready), "finish into a busy output")

  // a new result appears only after a warmup accept or a finish step
  `ASSERT_IMPLY(a_out_source, clk, rst, $rose(out_valid), $past((cmd.accept && sts.warm) || cmd.finish), "unexpected result")

  // a filtering request starts the median sweep on the next cycle
  `ASSERT_CLK(a_sweep_start, clk, rst, (cmd.accept && !sts.warm) |=> cmd.rank_step, "median sweep not started")

endmodule
